@@ design/assert_macros.svh @@
// assertion macros used by the checker in wsh_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/wsh_pkg.sv @@
// package: widths, register indexes and control types of the windowed histogram
package wsh_pkg;

    localparam int NUM_BINS   = 16;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int SAMPLE_W   = 32;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int EDGE_W     = DIFF_W + $clog2(NUM_BINS);
    localparam int CNT_W      = 16;
    localparam int WIN_W      = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_DATA_W = 24;
    localparam int IDX_EXT_W  = (BIN_W > OUT_IDX_W) ? BIN_W : OUT_IDX_W;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_VALUE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_VALUE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] MIN_RESET    = 32'sd0;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET    = 32'sd1310720000;
    localparam logic [WIN_W-1:0]           WINDOW_RESET = 16'd1024;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    typedef struct packed {
        logic capture;
        logic edge_en;
        logic cmp_en;
        logic update;
        logic rpt_load;
    } cmd_t;

    typedef struct packed {
        logic rpt_due;
        logic rpt_final;
        logic out_free;
    } sts_t;

    function automatic logic [OUT_IDX_W-1:0] bin_to_index(input logic [BIN_W-1:0] b);
        logic [IDX_EXT_W-1:0] t;
        t = IDX_EXT_W'(b);
        return t[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ design/wsh_ctrl.sv @@
// controller: sequences classify, count and report for one sample at a time
module wsh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  wsh_pkg::sts_t sts,
    output wsh_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EDGE = 5'b00010,
        S_CMP  = 5'b00100,
        S_UPD  = 5'b01000,
        S_RPT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EDGE;
                end
            end
            S_EDGE: begin
                cmd.edge_en = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP: begin
                cmd.cmp_en = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.update = 1'b1;
                state_next = sts.rpt_due ? S_RPT : S_IDLE;
            end
            S_RPT: begin
                if (sts.out_free) begin
                    cmd.rpt_load = 1'b1;
                    if (sts.rpt_final) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/wsh_datapath.sv @@
// datapath: config registers, bin edge compare, bin counters and output register
module wsh_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [wsh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [wsh_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [wsh_pkg::SAMPLE_W-1:0]      s_sample,
    input  logic                              s_last,
    input  wsh_pkg::cmd_t                     cmd,
    output wsh_pkg::sts_t                     sts,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [wsh_pkg::OUT_IDX_W-1:0]     m_bin_index,
    output logic [wsh_pkg::CNT_W-1:0]         m_bin_count,
    output logic                              m_window_last
);

    localparam int NB = wsh_pkg::NUM_BINS;
    localparam int EW = wsh_pkg::EDGE_W;
    localparam logic signed [EW-1:0] NB_S = EW'(NB);

    logic signed [wsh_pkg::SAMPLE_W-1:0] min_reg;
    logic signed [wsh_pkg::SAMPLE_W-1:0] max_reg;
    logic [wsh_pkg::WIN_W-1:0]           window_reg;

    logic signed [EW-1:0] d_reg;
    logic signed [EW-1:0] r_reg;
    logic                 last_reg;
    logic signed [EW-1:0] edge_reg [NB];
    logic [wsh_pkg::BIN_W-1:0] bin_reg;

    logic [wsh_pkg::CNT_W-1:0] cnt_reg [NB];
    logic [wsh_pkg::WIN_W-1:0] win_cnt_reg;
    logic [wsh_pkg::BIN_W-1:0] rpt_idx_reg;

    logic                          out_valid_reg;
    logic [wsh_pkg::OUT_IDX_W-1:0] out_idx_reg;
    logic [wsh_pkg::CNT_W-1:0]     out_cnt_reg;
    logic                          out_last_reg;

    logic signed [wsh_pkg::DIFF_W-1:0] diff_s;
    logic signed [wsh_pkg::DIFF_W-1:0] diff_r;
    logic signed [EW-1:0]              d_next;
    logic signed [EW-1:0]              r_next;
    logic [wsh_pkg::BIN_W-1:0]         bin_next;
    logic [NB-1:0]                     le;
    logic [wsh_pkg::BIN_W-1:0]         cnt_addr;
    logic [wsh_pkg::CNT_W-1:0]         cnt_rd;
    logic [wsh_pkg::WIN_W-1:0]         win_inc;
    logic                              rpt_due;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= wsh_pkg::MIN_RESET;
            max_reg    <= wsh_pkg::MAX_RESET;
            window_reg <= wsh_pkg::WINDOW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wsh_pkg::REG_MIN_VALUE:   min_reg    <= cfg_wdata[wsh_pkg::SAMPLE_W-1:0];
                wsh_pkg::REG_MAX_VALUE:   max_reg    <= cfg_wdata[wsh_pkg::SAMPLE_W-1:0];
                wsh_pkg::REG_WINDOW_SIZE: window_reg <= cfg_wdata[wsh_pkg::WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // scaled offset and range, exact in wide signed arithmetic
    assign diff_s = {s_sample[wsh_pkg::SAMPLE_W-1], s_sample}
                  - {min_reg[wsh_pkg::SAMPLE_W-1], min_reg};
    assign diff_r = {max_reg[wsh_pkg::SAMPLE_W-1], max_reg}
                  - {min_reg[wsh_pkg::SAMPLE_W-1], min_reg};
    assign d_next = EW'(diff_s) * NB_S;
    assign r_next = EW'(diff_r);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            d_reg    <= d_next;
            r_reg    <= r_next;
            last_reg <= s_last;
        end
    end

    // upper edge of every bin
    always_ff @(posedge aclk) begin
        if (cmd.edge_en) begin
            for (int i = 0; i < NB; i++) begin
                edge_reg[i] <= r_reg * EW'(i + 1);
            end
        end
    end

    // first bin whose edge is not below the sample
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            le[i] = (d_reg <= edge_reg[i]);
        end
        bin_next = wsh_pkg::LAST_BIN;
        for (int i = NB - 1; i >= 0; i--) begin
            if (le[i]) begin
                bin_next = wsh_pkg::BIN_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cmp_en) begin
            bin_reg <= bin_next;
        end
    end

    assign cnt_addr = cmd.rpt_load ? rpt_idx_reg : bin_reg;
    assign cnt_rd   = cnt_reg[cnt_addr];
    assign win_inc  = win_cnt_reg + 1'b1;
    assign rpt_due  = last_reg || (win_inc >= window_reg);

    // bin counters, window count and report index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) begin
                cnt_reg[i] <= '0;
            end
            win_cnt_reg <= '0;
            rpt_idx_reg <= '0;
        end else begin
            if (cmd.update) begin
                if (cnt_rd != {wsh_pkg::CNT_W{1'b1}}) begin
                    cnt_reg[cnt_addr] <= cnt_rd + 1'b1;
                end
                win_cnt_reg <= rpt_due ? '0 : win_inc;
            end
            if (cmd.rpt_load) begin
                cnt_reg[cnt_addr] <= '0;
                rpt_idx_reg <= (rpt_idx_reg == wsh_pkg::LAST_BIN) ? '0 : rpt_idx_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.rpt_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rpt_load) begin
            out_idx_reg  <= wsh_pkg::bin_to_index(rpt_idx_reg);
            out_cnt_reg  <= cnt_rd;
            out_last_reg <= (rpt_idx_reg == wsh_pkg::LAST_BIN);
        end
    end

    assign sts.rpt_due   = rpt_due;
    assign sts.rpt_final = (rpt_idx_reg == wsh_pkg::LAST_BIN);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign m_bin_index   = out_idx_reg;
    assign m_bin_count   = out_cnt_reg;
    assign m_window_last = out_last_reg;

endmodule

@@ design/windowed_sample_histogram_core.sv @@
// top level: windowed histogram of Q16.16 samples over uniform bins
//
// input stream: s_tdata carries one signed Q16.16 sample per beat, s_tlast
// closes the current window early after that sample is counted.
// output stream: one beat per bin in index order during a report, with
// m_tlast on the final bin of the window.
// config port: cfg_we writes cfg_wdata into register cfg_addr
// (0 min_value, 1 max_value, 2 window_size); other indexes are ignored.
// each sample passes through capture, edge scaling, parallel edge
// compare and counter update; s_tready is high only between samples.
// a full or flushed window then emits NUM_BINS beats at one per cycle
// from the output register, after which the next sample is taken; the
// output register lets that sample enter while the final beat is pending.
// a stalled m_tready holds the current beat and pauses the report.
// reset clears all bin counters and the window count and restores the
// register defaults; no clearing pass is needed.
module windowed_sample_histogram_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wsh_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] sample
    input  logic                              s_tlast,   // last_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wsh_pkg::OUT_DATA_W-1:0]    m_tdata,   // [3:0] bin_index, [19:4] bin_count
    output logic                              m_tlast,   // window_last
    input  logic                              cfg_we,
    input  logic [wsh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [wsh_pkg::CFG_W-1:0]         cfg_wdata
);

    wsh_pkg::cmd_t cmd;
    wsh_pkg::sts_t sts;

    logic [wsh_pkg::OUT_IDX_W-1:0] bin_index;
    logic [wsh_pkg::CNT_W-1:0]     bin_count;

    wsh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsh_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_sample      (s_tdata),
        .s_last        (s_tlast),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_bin_index   (bin_index),
        .m_bin_count   (bin_count),
        .m_window_last (m_tlast)
    );

    assign m_tdata = {{(wsh_pkg::OUT_DATA_W - wsh_pkg::OUT_IDX_W - wsh_pkg::CNT_W){1'b0}},
                      bin_count, bin_index};

endmodule

@@ design/wsh_checker.sv @@
// checker on the top-level ports of the histogram, with its bind
`include "assert_macros.svh"

module wsh_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic                           m_tlast
);

    // a pending beat stays until taken
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // the block is busy in the cycle after it takes a sample
    `ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // s_tready is low in the cycle that the first beat of a report appears
    `ASSERT_SAME(a_report_blocks_in, aclk, aresetn, $rose(m_tvalid), !s_tready)

    // the final-bin flag of a waiting beat holds until taken
    `ASSERT_NEXT(a_last_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tlast))

endmodule

bind windowed_sample_histogram_core wsh_checker u_wsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

@@ test/windowed_sample_histogram_core_tb.sv @@
// testbench: windowed sample histogram core checked beat by beat against a bin-count predictor
module windowed_sample_histogram_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [wsh_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [wsh_pkg::OUT_IDX_W-1:0] idx;
        logic [wsh_pkg::CNT_W-1:0]     count;
        logic                          closes;
    } bin_beat_t;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_CHOKED, RX_TOGGLE} rx_mode_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [wsh_pkg::SAMPLE_W-1:0]   s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [wsh_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [wsh_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [wsh_pkg::CFG_W-1:0]      cfg_wdata = '0;

    windowed_sample_histogram_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [wsh_pkg::SAMPLE_W-1:0] range_lo   = wsh_pkg::MIN_RESET;
    logic signed [wsh_pkg::SAMPLE_W-1:0] range_hi   = wsh_pkg::MAX_RESET;
    logic [wsh_pkg::WIN_W-1:0]           window_len = wsh_pkg::WINDOW_RESET;
    logic [wsh_pkg::CNT_W-1:0]           bin_tally [wsh_pkg::NUM_BINS];
    logic [wsh_pkg::WIN_W-1:0]           window_fill = '0;
    bin_beat_t                           expected_bins [$];

    int  mismatches      = 0;
    int  samples_sent    = 0;
    int  reports_checked = 0;
    int  reg_writes      = 0;
    int  cycle_count     = 0;
    int  burst_left      = 0;
    bit  pacing_on       = 1'b1;

    rx_mode_t rx_mode = RX_STEADY;
    int       rx_left = 0;

    initial begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
    end

    function automatic int bin_of_sample(input logic signed [wsh_pkg::SAMPLE_W-1:0] s);
        longint scaled;
        longint span;
        scaled = (longint'(s) - longint'(range_lo)) * wsh_pkg::NUM_BINS;
        span   = longint'(range_hi) - longint'(range_lo);
        for (int i = 0; i < wsh_pkg::NUM_BINS; i++) begin
            if (scaled <= longint'(i + 1) * span) return i;
        end
        return wsh_pkg::NUM_BINS - 1;
    endfunction

    task automatic count_sample(input logic [wsh_pkg::SAMPLE_W-1:0] s, input logic closes);
        int b;
        bin_beat_t beat;
        b = bin_of_sample(s);
        if (bin_tally[b] != {wsh_pkg::CNT_W{1'b1}}) bin_tally[b] = bin_tally[b] + 1'b1;
        window_fill = window_fill + 1'b1;
        if (closes || window_fill >= window_len) begin
            for (int i = 0; i < wsh_pkg::NUM_BINS; i++) begin
                beat.idx    = wsh_pkg::OUT_IDX_W'(i);
                beat.count  = bin_tally[i];
                beat.closes = (i == wsh_pkg::NUM_BINS - 1);
                expected_bins.push_back(beat);
                bin_tally[i] = '0;
            end
            window_fill = '0;
        end
    endtask

    task automatic write_reg(input logic [wsh_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [wsh_pkg::CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            wsh_pkg::REG_MIN_VALUE:   range_lo   = data;
            wsh_pkg::REG_MAX_VALUE:   range_hi   = data;
            wsh_pkg::REG_WINDOW_SIZE: window_len = data[wsh_pkg::WIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [wsh_pkg::SAMPLE_W-1:0] value, input logic closes);
        int gap;
        if (pacing_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        count_sample(value, closes);
    endtask

    // stop feeding, let every pending bin beat drain, then let the pipeline go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_CHOKED: m_tready <= ($urandom_range(0, 4) == 0);
            RX_TOGGLE: m_tready <= ~m_tready;
            default:   m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        bin_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bins.size() == 0) begin
                mismatches++;
                $display("%0t: expected no beat, got idx %0d count %0d last %0b", $time,
                         m_tdata[3:0], m_tdata[19:4], m_tlast);
            end else begin
                want = expected_bins.pop_front();
                if (m_tdata[3:0] !== want.idx || m_tdata[19:4] !== want.count ||
                    m_tlast !== want.closes) begin
                    mismatches++;
                    $display("%0t: expected idx %0d count %0d last %0b, got idx %0d count %0d last %0b",
                             $time, want.idx, want.count, want.closes,
                             m_tdata[3:0], m_tdata[19:4], m_tlast);
                end
                if (want.closes) reports_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // reset values: range 0 to 20000.0, bin edges every 1250.0
    task automatic check_default_range();
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'd81920000, 1'b0);
        send_sample(32'd81920001, 1'b0);
        send_sample(32'd1310720000, 1'b0);
        send_sample(32'd1310720001, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        settle();
    endtask

    task automatic check_window_lengths();
        write_reg(wsh_pkg::REG_WINDOW_SIZE, 32'h0000_0001);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0);
        settle();
        // upper bits are dropped, leaving a zero length
        write_reg(wsh_pkg::REG_WINDOW_SIZE, 32'hFFFF_0000);
        send_sample(32'h0200_0000, 1'b0);
        send_sample(32'h4000_0000, 1'b1);
        settle();
    endtask

    task automatic check_range_shapes();
        write_reg(wsh_pkg::REG_WINDOW_SIZE, 32'h0000_FFFF);
        // reversed
        write_reg(wsh_pkg::REG_MIN_VALUE, 32'h03E8_0000);
        write_reg(wsh_pkg::REG_MAX_VALUE, 32'hFC18_0000);
        send_sample(32'h03E8_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hF000_0000, 1'b1);
        settle();
        // empty
        write_reg(wsh_pkg::REG_MIN_VALUE, 32'd5);
        write_reg(wsh_pkg::REG_MAX_VALUE, 32'd5);
        send_sample(32'd4, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd6, 1'b1);
        settle();
        // full signed span, then a write to an unmapped index that must change nothing
        write_reg(wsh_pkg::REG_MIN_VALUE, 32'h8000_0000);
        write_reg(wsh_pkg::REG_MAX_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        settle();
    endtask

    task automatic check_window_shrink();
        write_reg(wsh_pkg::REG_WINDOW_SIZE, 32'd100);
        for (int i = 0; i < 5; i++) send_sample($urandom, 1'b0);
        settle();
        write_reg(wsh_pkg::REG_WINDOW_SIZE, 32'd3);
        send_sample($urandom, 1'b0);
        settle();
    endtask

    task automatic check_random_windows();
        longint lo;
        longint hi;
        longint span;
        longint pick;
        longint a;
        longint b;
        int     off;
        int     k;
        logic [wsh_pkg::WIN_W-1:0] win;
        for (int phase = 0; phase < 12; phase++) begin
            settle();
            lo = longint'($signed($urandom)) / 2;
            span = $urandom_range(16, 32'h4000_0000);
            case ($urandom_range(0, 5))
                0: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
                1: hi = lo - span;
                2: begin lo = longint'($signed($urandom)); hi = longint'($signed($urandom)); end
                3: hi = lo;
                default: hi = lo + span;
            endcase
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            if (hi < -64'sd2147483648) hi = -64'sd2147483648;
            k = $urandom_range(0, 9);
            win = (k < 7) ? wsh_pkg::WIN_W'($urandom_range(1, 24)) :
                  (k == 7) ? '0 : wsh_pkg::WIN_W'($urandom_range(25, 300));
            write_reg(wsh_pkg::REG_MIN_VALUE, wsh_pkg::CFG_W'(lo));
            write_reg(wsh_pkg::REG_MAX_VALUE, wsh_pkg::CFG_W'(hi));
            write_reg(wsh_pkg::REG_WINDOW_SIZE, {16'($urandom), win});
            a = (lo < hi) ? lo : hi;
            b = (lo < hi) ? hi : lo;
            for (int n = 0; n < 26; n++) begin
                if (n == 13) settle();
                k = $urandom_range(0, 99);
                if (k < 65) begin
                    pick = a + (longint'($urandom) % (b - a + 1));
                end else if (k < 85) begin
                    off  = $urandom_range(0, 2);
                    pick = lo + (longint'($urandom_range(1, wsh_pkg::NUM_BINS)) * (hi - lo))
                           / wsh_pkg::NUM_BINS + off - 1;
                end else begin
                    pick = longint'($urandom);
                end
                send_sample(wsh_pkg::SAMPLE_W'(pick), ($urandom_range(0, 19) == 0));
            end
        end
        send_sample($urandom, 1'b1);
        settle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_default_range();
        check_window_lengths();
        check_range_shapes();
        check_window_shrink();
        check_random_windows();
        settle();
        if (expected_bins.size() != 0) begin
            mismatches++;
            $display("%0t: %0d bin beats never arrived", $time, expected_bins.size());
        end
        $display("covered %0d samples over %0d register writes: reversed, empty and full ranges,",
                 samples_sent, reg_writes);
        $display("zero, shrunk and longest windows; %0d window reports compared", reports_checked);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
